[rtl/qau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Types, constants and saturation helpers shared by the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 4;
  localparam int MAT_ROWS  = 4;
  localparam int ROW_W     = $clog2(MAT_ROWS);

  localparam logic [DATA_W-1:0]        ONE      = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  ONE_S    = SUM_W'(1) <<< FRAC_BITS;
  localparam logic [ROW_W-1:0]         LAST_ROW = ROW_W'(MAT_ROWS - 1);

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_ROT  = 3'd1,
    OP_CONJ = 3'd2,
    OP_DOT  = 3'd3,
    OP_MAT  = 3'd4
  } op_e;

  // cross terms: xy-wz, xy+wz, xz-wy, xz+wy, yz-wx, yz+wx
  localparam logic [2:0] CR_SEL  [3][2] = '{'{3'd0, 3'd3}, '{3'd1, 3'd4}, '{3'd2, 3'd5}};
  localparam logic [1:0] VEC_SEL [3][2] = '{'{2'd1, 2'd2}, '{2'd0, 2'd2}, '{2'd0, 2'd1}};
  localparam logic [3:0] SQ_NEG  [3]    = '{4'b1100, 4'b1010, 4'b0110};

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r0;
    logic signed [DATA_W-1:0] r1;
    logic signed [DATA_W-1:0] r2;
    logic signed [DATA_W-1:0] r3;
    logic                     overflow;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic [2:0]             op;
    logic [3:0][DATA_W-1:0] a;
    logic [2:0][DATA_W-1:0] vec;
  } s1_t;

  typedef struct packed {
    logic [2:0]                  op;
    logic [2:0][3:0][DATA_W-1:0] row;
    logic [2:0]                  row_ovf;
    logic [3:0][DATA_W-1:0]      sq;
    logic [5:0][DATA_W-1:0]      cr;
    logic [2:0][DATA_W-1:0]      vec;
    logic                        rot_ovf;
  } s2_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] v;
  } sat_t;

  function automatic logic signed [SUM_W-1:0] ext(input logic [PROD_W-1:0] p);
    return SUM_W'($signed(p));
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_d(input logic [DATA_W-1:0] v);
    return SUM_W'($signed(v));
  endfunction

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] s);
    sat_t r;
    logic fits;
    fits  = (&s[SUM_W-1:DATA_W-1]) || (~|s[SUM_W-1:DATA_W-1]);
    r.ovf = !fits;
    if (fits) begin
      r.v = s[DATA_W-1:0];
    end else if (s[SUM_W-1]) begin
      r.v = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r.v = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/qau_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_mul
// One multiplier lane: signed product, scaled down by the fraction bits with
// rounding toward minus infinity, and registered.
// ----------------------------------------------------------------------------
module qau_mul
  import qau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic [PROD_W-1:0]        p_o
);

  logic signed [2*DATA_W-1:0] full;
  logic [PROD_W-1:0]          p_d;
  logic [PROD_W-1:0]          p_q;

  assign full = a_i * b_i;
  assign p_d  = full[2*DATA_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/qau_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_merge
// Combine the sixteen lane products into product, dot and matrix results, and
// the saturated pair terms for the rotation lanes; a conjugate negates x, y, z.
// ----------------------------------------------------------------------------
module qau_merge
  import qau_pkg::*;
(
  input  s1_t                         s1_i,
  input  logic [3:0][3:0][PROD_W-1:0] p_i,
  output s2_t                         s2_o
);

  always_comb begin
    sat_t sq_s [4];
    sat_t wx_s, wy_s, wz_s, xy_s, xz_s, yz_s;
    sat_t cr_s [6];
    sat_t m [4];
    sat_t e [3][3];
    logic signed [SUM_W-1:0] d_xx, d_yy, d_zz, d_xy, d_zw, d_xz, d_yw, d_yz, d_xw;

    s2_o     = '0;
    s2_o.op  = s1_i.op;
    s2_o.vec = s1_i.vec;

    for (int i = 0; i < 4; i++) begin
      sq_s[i]    = sat32(ext(p_i[i][i]));
      s2_o.sq[i] = sq_s[i].v;
    end
    wx_s = sat32(ext(p_i[0][1]));
    wy_s = sat32(ext(p_i[0][2]));
    wz_s = sat32(ext(p_i[0][3]));
    xy_s = sat32(ext(p_i[1][2]));
    xz_s = sat32(ext(p_i[1][3]));
    yz_s = sat32(ext(p_i[2][3]));
    cr_s[0] = sat32(ext_d(xy_s.v) - ext_d(wz_s.v));
    cr_s[1] = sat32(ext_d(xy_s.v) + ext_d(wz_s.v));
    cr_s[2] = sat32(ext_d(xz_s.v) - ext_d(wy_s.v));
    cr_s[3] = sat32(ext_d(xz_s.v) + ext_d(wy_s.v));
    cr_s[4] = sat32(ext_d(yz_s.v) - ext_d(wx_s.v));
    cr_s[5] = sat32(ext_d(yz_s.v) + ext_d(wx_s.v));
    for (int i = 0; i < 6; i++) begin
      s2_o.cr[i] = cr_s[i].v;
    end
    s2_o.rot_ovf = sq_s[0].ovf | sq_s[1].ovf | sq_s[2].ovf | sq_s[3].ovf
                 | wx_s.ovf | wy_s.ovf | wz_s.ovf | xy_s.ovf | xz_s.ovf | yz_s.ovf
                 | cr_s[0].ovf | cr_s[1].ovf | cr_s[2].ovf
                 | cr_s[3].ovf | cr_s[4].ovf | cr_s[5].ovf;

    m[0] = sat32(ext(p_i[0][0]) - ext(p_i[1][1]) - ext(p_i[2][2]) - ext(p_i[3][3]));
    m[1] = sat32(ext(p_i[0][1]) + ext(p_i[1][0]) + ext(p_i[2][3]) - ext(p_i[3][2]));
    m[2] = sat32(ext(p_i[0][2]) - ext(p_i[1][3]) + ext(p_i[2][0]) + ext(p_i[3][1]));
    m[3] = sat32(ext(p_i[0][3]) + ext(p_i[1][2]) - ext(p_i[2][1]) + ext(p_i[3][0]));

    d_xx = ext(p_i[1][1]) <<< 1;
    d_yy = ext(p_i[2][2]) <<< 1;
    d_zz = ext(p_i[3][3]) <<< 1;
    d_xy = ext(p_i[1][2]) <<< 1;
    d_zw = ext(p_i[0][3]) <<< 1;
    d_xz = ext(p_i[1][3]) <<< 1;
    d_yw = ext(p_i[0][2]) <<< 1;
    d_yz = ext(p_i[2][3]) <<< 1;
    d_xw = ext(p_i[0][1]) <<< 1;
    e[0][0] = sat32(ONE_S - d_yy - d_zz);
    e[0][1] = sat32(d_xy + d_zw);
    e[0][2] = sat32(d_xz - d_yw);
    e[1][0] = sat32(d_xy - d_zw);
    e[1][1] = sat32(ONE_S - d_xx - d_zz);
    e[1][2] = sat32(d_yz + d_xw);
    e[2][0] = sat32(d_xz + d_yw);
    e[2][1] = sat32(d_yz - d_xw);
    e[2][2] = sat32(ONE_S - d_xx - d_yy);

    case (s1_i.op)
      OP_MUL: begin
        for (int k = 0; k < 4; k++) begin
          s2_o.row[0][k] = m[k].v;
        end
        s2_o.row_ovf[0] = m[0].ovf | m[1].ovf | m[2].ovf | m[3].ovf;
      end
      OP_DOT: begin
        m[0] = sat32(ext(p_i[0][0]) + ext(p_i[1][1]) + ext(p_i[2][2]) + ext(p_i[3][3]));
        s2_o.row[0][0]  = m[0].v;
        s2_o.row_ovf[0] = m[0].ovf;
      end
      OP_CONJ: begin
        s2_o.row[0][0] = s1_i.a[0];
        for (int k = 1; k < 4; k++) begin
          m[k]           = sat32(-ext_d(s1_i.a[k]));
          s2_o.row[0][k] = m[k].v;
        end
        s2_o.row_ovf[0] = m[1].ovf | m[2].ovf | m[3].ovf;
      end
      OP_MAT: begin
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) begin
            s2_o.row[r][k] = e[r][k].v;
          end
          s2_o.row_ovf[r] = e[r][0].ovf | e[r][1].ovf | e[r][2].ovf;
        end
      end
      default: begin
        s2_o.row_ovf = '0;
      end
    endcase
  end

endmodule

[rtl/qau_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_out
// Sum the rotation lane products, then hold result rows and hand them out one
// item at a time; a matrix item drains four rows.
// ----------------------------------------------------------------------------
module qau_out
  import qau_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  s2_t                          s3_i,
  input  logic [2:0][5:0][PROD_W-1:0]  q_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output res_t                         out_o
);

  logic                        valid_d, valid_q;
  logic                        mat_d, mat_q;
  logic [ROW_W-1:0]            cnt_d, cnt_q;
  logic [2:0][3:0][DATA_W-1:0] rows_d, rows_q;
  logic [2:0]                  ovf_d, ovf_q;
  logic                        last;
  sat_t                        rs [3];

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = (ext(q_i[r][4]) + ext(q_i[r][5])) <<< 1;
      for (int k = 0; k < 4; k++) begin
        if (SQ_NEG[r][k]) begin
          acc = acc - ext(q_i[r][k]);
        end else begin
          acc = acc + ext(q_i[r][k]);
        end
      end
      rs[r] = sat32(acc);
    end
  end

  assign last   = !mat_q || (cnt_q == LAST_ROW);
  assign take_o = !valid_q || (!out_stall_i && last);

  always_comb begin
    valid_d = valid_q;
    mat_d   = mat_q;
    cnt_d   = cnt_q;
    rows_d  = rows_q;
    ovf_d   = ovf_q;
    if (take_o) begin
      valid_d = load_i;
      mat_d   = load_i && (s3_i.op == OP_MAT);
      cnt_d   = '0;
      if (s3_i.op == OP_ROT) begin
        rows_d      = '0;
        ovf_d       = '0;
        for (int k = 0; k < 3; k++) begin
          rows_d[0][k] = rs[k].v;
        end
        ovf_d[0] = s3_i.rot_ovf | rs[0].ovf | rs[1].ovf | rs[2].ovf;
      end else begin
        rows_d = s3_i.row;
        ovf_d  = s3_i.row_ovf;
      end
    end else if (valid_q && !out_stall_i) begin
      cnt_d = cnt_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mat_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      mat_q   <= mat_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q <= rows_d;
    ovf_q  <= ovf_d;
  end

  always_comb begin
    out_o      = '0;
    out_o.last = last;
    if (mat_q && cnt_q == LAST_ROW) begin
      out_o.r3 = ONE;
    end else begin
      out_o.r1       = rows_q[cnt_q][1];
      out_o.r2       = rows_q[cnt_q][2];
      out_o.r3       = rows_q[cnt_q][3];
      out_o.r0       = rows_q[cnt_q][0];
      out_o.overflow = ovf_q[cnt_q];
    end
  end

  assign out_valid_o = valid_q;

  a_single_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !mat_q |-> cnt_q == '0)
    else $error("non-matrix item advanced its row counter");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_stall_i && !last |=> valid_q && cnt_q == $past(cnt_q) + ROW_W'(1))
    else $error("matrix rows did not advance in order");

  a_mat_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && mat_q && cnt_q == LAST_ROW |-> out_o.last && !out_o.overflow)
    else $error("matrix tail row malformed");

endmodule

[rtl/quaternion_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q16.16 quaternion product, vector rotation, conjugate, dot and matrix.
// An accepted item passes the lane products, merge, rotation products and the
// single output register. Throughput: one item per cycle unless the output
// stalls or a matrix item drains its four rows, one row at a time.
// Reset clears all pipeline valid bits and the row counter; no other wait.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_o
);

  logic                        v1_d, v1_q, v2_d, v2_q, v3_d, v3_q;
  logic                        en1, en2, en3, en_out;
  logic                        op_ok, self_mul;
  logic [3:0][DATA_W-1:0]      in_a, in_b;
  s1_t                         s1_d, s1_q;
  s2_t                         s2_d, s2_q, s3_q;
  logic [3:0][3:0][PROD_W-1:0] p1;
  logic [2:0][5:0][PROD_W-1:0] q3;

  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  assign op_ok    = in_i.op inside {OP_MUL, OP_ROT, OP_CONJ, OP_DOT, OP_MAT};
  assign self_mul = (in_i.op == OP_ROT) || (in_i.op == OP_MAT);
  assign in_a     = {in_i.a_z, in_i.a_y, in_i.a_x, in_i.a_w};
  assign in_b     = self_mul ? in_a : {in_i.b_z, in_i.b_y, in_i.b_x, in_i.b_w};

  always_comb begin
    s1_d.op  = in_i.op;
    s1_d.a   = in_a;
    s1_d.vec = {in_i.b_z, in_i.b_y, in_i.b_x};
  end

  for (genvar i = 0; i < 4; i++) begin : g_pi
    for (genvar j = 0; j < 4; j++) begin : g_pj
      qau_mul u_mul (
        .clk_i (clk_i),
        .en_i  (en1),
        .a_i   (in_a[i]),
        .b_i   (in_b[j]),
        .p_o   (p1[i][j])
      );
    end
  end

  qau_merge u_merge (
    .s1_i (s1_q),
    .p_i  (p1),
    .s2_o (s2_d)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 6; k++) begin : g_term
      logic [DATA_W-1:0] op_a, op_b;
      if (k < 4) begin : g_sq
        assign op_a = s2_q.sq[k];
        assign op_b = s2_q.vec[r];
      end else begin : g_cr
        assign op_a = s2_q.cr[CR_SEL[r][k-4]];
        assign op_b = s2_q.vec[VEC_SEL[r][k-4]];
      end
      qau_mul u_mul (
        .clk_i (clk_i),
        .en_i  (en3),
        .a_i   (op_a),
        .b_i   (op_b),
        .p_o   (q3[r][k])
      );
    end
  end

  qau_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (v3_q),
    .s3_i        (s3_q),
    .q_i         (q3),
    .take_o      (en_out),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always_comb begin
    v1_d = en1 ? (in_valid_i && op_ok) : v1_q;
    v2_d = en2 ? v1_q : v2_q;
    v3_d = en3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s2_q;
    end
  end

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q)
    else $error("input stalled with a free stage");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_ok |=> v1_q)
    else $error("accepted item lost at first stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en2 |=> v2_q && $stable(s2_q))
    else $error("stalled stage dropped its item");

endmodule
